FILE: hw/rtl/line_edit_buffer_assert.svh
// Assertion macros for the line edit buffer.
`ifndef LINE_EDIT_BUFFER_ASSERT_SVH
`define LINE_EDIT_BUFFER_ASSERT_SVH
`ifndef ASSERT_OFF
`define LEB_ASSERT(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("line_edit_buffer: check failed");
`define LEB_ASSERT_IMPL(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("line_edit_buffer: implication failed");
`else
`define LEB_ASSERT(lbl, expr)
`define LEB_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

FILE: hw/rtl/leb_pkg.sv
`timescale 1ns / 1ps

package leb_pkg;

	localparam int LINE_CAPACITY = 63;
	localparam int FILL_W        = $clog2(LINE_CAPACITY + 1);
	localparam int ADDR_W        = $clog2(LINE_CAPACITY);
	localparam int CHAR_W        = 8;
	localparam int CFG_IDX_W     = 2;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
	localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

	localparam logic [CHAR_W-1:0] PRINT_CODE_RST      = 8'd64;
	localparam logic [CHAR_W-1:0] ERASE_CODE_RST      = 8'd42;
	localparam logic [CHAR_W-1:0] WORD_ERASE_CODE_RST = 8'd36;
	localparam logic [CHAR_W-1:0] CLEAR_CODE_RST      = 8'd38;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PRINT      = 2'd0,
		CFG_ERASE      = 2'd1,
		CFG_WORD_ERASE = 2'd2,
		CFG_CLEAR      = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_APPEND,
		OP_ERASE,
		OP_WORD,
		OP_CLEAR,
		OP_PRINT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHAR_W-1:0] ch;
	} cmd_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_PRINT,
		BK_NEWLINE
	} back_state_t;

	typedef struct packed {
		logic              walking;
		logic [FILL_W-1:0] fill;
		logic [ADDR_W-1:0] idx;
	} back_status_t;

endpackage

FILE: hw/rtl/leb_front.sv
`timescale 1ns / 1ps

module leb_front import leb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CHAR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	input  logic [CHAR_W-1:0]    in_char,
	input  logic                 q_full,
	output logic                 push,
	output cmd_t                 push_cmd
);

	logic [CHAR_W-1:0] print_code_q;
	logic [CHAR_W-1:0] erase_code_q;
	logic [CHAR_W-1:0] word_erase_code_q;
	logic [CHAR_W-1:0] clear_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			print_code_q      <= PRINT_CODE_RST;
			erase_code_q      <= ERASE_CODE_RST;
			word_erase_code_q <= WORD_ERASE_CODE_RST;
			clear_code_q      <= CLEAR_CODE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PRINT:      print_code_q      <= cfg_data;
				CFG_ERASE:      erase_code_q      <= cfg_data;
				CFG_WORD_ERASE: word_erase_code_q <= cfg_data;
				CFG_CLEAR:      clear_code_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	assign push        = in_valid && !q_full;
	assign push_cmd.ch = in_char;

	always_comb begin
		if (in_char == print_code_q) begin
			push_cmd.op = OP_PRINT;
		end else if (in_char == erase_code_q) begin
			push_cmd.op = OP_ERASE;
		end else if (in_char == word_erase_code_q) begin
			push_cmd.op = OP_WORD;
		end else if (in_char == clear_code_q) begin
			push_cmd.op = OP_CLEAR;
		end else begin
			push_cmd.op = OP_APPEND;
		end
	end

endmodule

FILE: hw/rtl/leb_cmd_queue.sv
`timescale 1ns / 1ps

module leb_cmd_queue import leb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  cmd_t              push_cmd,
	input  logic              pop,
	output logic              cmd_valid,
	output cmd_t              cmd,
	output logic              full,
	output logic [QCNT_W-1:0] count
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	cmd_t              entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_pop;

	assign do_pop    = pop && (count_q != '0);
	assign cmd_valid = (count_q != '0);
	assign cmd       = entry_q[rd_ptr_q];
	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: hw/rtl/leb_back.sv
`timescale 1ns / 1ps

module leb_back import leb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CHAR_W-1:0] out_char,
	output logic              last_of_line,
	output back_status_t      status
);

	logic [CHAR_W-1:0] line_store [LINE_CAPACITY];
	logic [CHAR_W-1:0] rdata_q;

	back_state_t       state_q, state_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [ADDR_W-1:0] idx_q, idx_d;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;

	logic              out_valid_q;
	logic [CHAR_W-1:0] out_char_q;
	logic              out_last_q;
	logic              out_free;
	logic              load_out;
	logic [CHAR_W-1:0] load_char;
	logic              load_last;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_store[wr_addr] <= cmd.ch;
		end
		rdata_q <= line_store[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			fill_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		idx_d     = idx_q;
		rd_addr   = idx_q;
		wr_addr   = fill_q[ADDR_W-1:0];
		wr_en     = 1'b0;
		pop       = 1'b0;
		load_out  = 1'b0;
		load_char = NEWLINE_CHAR;
		load_last = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (cmd_valid) begin
					pop = 1'b1;
					case (cmd.op)
						OP_APPEND: begin
							if (fill_q < FILL_W'(LINE_CAPACITY)) begin
								wr_en  = 1'b1;
								fill_d = fill_q + 1'b1;
							end
						end
						OP_ERASE: begin
							if (fill_q != '0) begin
								fill_d = fill_q - 1'b1;
							end
						end
						OP_CLEAR: begin
							fill_d = '0;
						end
						OP_WORD: begin
							if (fill_q != '0) begin
								idx_d   = ADDR_W'(fill_q - 1'b1);
								rd_addr = idx_d;
								state_d = BK_WALK;
							end
						end
						OP_PRINT: begin
							idx_d   = '0;
							rd_addr = '0;
							state_d = (fill_q == '0) ? BK_NEWLINE : BK_PRINT;
						end
						default: ;
					endcase
				end
			end
			BK_WALK: begin
				if (idx_q == '0) begin
					fill_d  = '0;
					state_d = BK_IDLE;
				end else if (rdata_q == SPACE_CHAR) begin
					fill_d  = FILL_W'(idx_q);
					state_d = BK_IDLE;
				end else begin
					idx_d   = idx_q - 1'b1;
					rd_addr = idx_d;
				end
			end
			BK_PRINT: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_char = rdata_q;
					if (FILL_W'(idx_q) == fill_q - 1'b1) begin
						state_d = BK_NEWLINE;
					end else begin
						idx_d   = idx_q + 1'b1;
						rd_addr = idx_d;
					end
				end
			end
			BK_NEWLINE: begin
				if (out_free) begin
					load_out  = 1'b1;
					load_last = 1'b1;
					fill_d    = '0;
					state_d   = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_char_q <= load_char;
			out_last_q <= load_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_char     = out_char_q;
	assign last_of_line = out_last_q;

	assign status.walking = (state_q == BK_WALK);
	assign status.fill    = fill_q;
	assign status.idx     = idx_q;

endmodule

FILE: hw/rtl/line_edit_buffer.sv
// Append, erase and clear pass through the command queue before updating the fill count.
// One editing character per cycle while in_stall is low and the back end is idle.
// Word erase walks back, one line store read per cycle, until a space or the line start.
// Print output is registered; fill + 1 transactions (characters, then newline) follow,
// one per cycle when out_stall is low.
// Reset: fill count, queue, control and codes reset at once; line store is not cleared.
`timescale 1ns / 1ps
`include "line_edit_buffer_assert.svh"

module line_edit_buffer import leb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CHAR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [CHAR_W-1:0]    in_char,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [CHAR_W-1:0]    out_char,
	output logic                 last_of_line
);

	logic              push;
	cmd_t              push_cmd;
	logic              q_full;
	logic [QCNT_W-1:0] q_count;
	logic              cmd_valid;
	cmd_t              cmd;
	logic              pop;
	back_status_t      bk_status;

	assign in_stall = q_full;

	leb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_char   (in_char),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	leb_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.full      (q_full),
		.count     (q_count)
	);

	leb_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd          (cmd),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.last_of_line (last_of_line),
		.status       (bk_status)
	);

	`LEB_ASSERT_IMPL(a_walk_in_line, bk_status.walking, FILL_W'(bk_status.idx) < bk_status.fill)
	`LEB_ASSERT_IMPL(a_stall_when_full, in_stall, q_count == QCNT_W'(QUEUE_DEPTH))
	`LEB_ASSERT_IMPL(a_last_is_newline, out_valid && last_of_line, out_char == NEWLINE_CHAR)

endmodule
